// File: hdl/abbr_pkg.sv
// ----------------------------------------------------------------------------
// abbr_pkg
// Shared constants, codes and types for the audio block buffer ring.
// ----------------------------------------------------------------------------
package abbr_pkg;

    localparam int BLOCK_SAMPLES = 256;
    localparam int BLOCK_COUNT   = 4;

    localparam int BLK_W  = $clog2(BLOCK_COUNT);
    localparam int POS_W  = $clog2(BLOCK_SAMPLES + 1);
    localparam int ADDR_W = $clog2(BLOCK_COUNT * BLOCK_SAMPLES);
    localparam int SMP_W  = 16;

    // Operation codes.
    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_FETCH   = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    // Block status codes.
    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_WRITTEN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_READ    = 2'd3;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [SMP_W-1:0]  wdata;
        logic                     re;
        logic [ADDR_W-1:0]        raddr;
    } mem_req_t;

    typedef struct packed {
        logic        strobe;
        logic [1:0]  state;
        logic        dropped;
        logic [1:0]  blk;
        logic        fetch_ok;
    } result_t;

    function automatic logic [BLK_W-1:0] next_blk(input logic [BLK_W-1:0] b);
        logic [BLK_W-1:0] n;
        if (32'(b) == BLOCK_COUNT - 1)
        begin
            n = '0;
        end
        else
        begin
            n = b + 1'b1;
        end
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] sample_addr(input logic [BLK_W-1:0] b,
                                                      input logic [POS_W-1:0] p);
        return ADDR_W'(b) * ADDR_W'(BLOCK_SAMPLES) + ADDR_W'(p);
    endfunction

endpackage

// File: hdl/abbr_sample_mem.sv
// ----------------------------------------------------------------------------
// abbr_sample_mem
// Sample storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module abbr_sample_mem
    import abbr_pkg::*;
(
    input  logic                    clk,
    input  mem_req_t                req,
    output logic signed [SMP_W-1:0] rdata
);

    logic signed [SMP_W-1:0] mem_reg [BLOCK_COUNT*BLOCK_SAMPLES];
    logic signed [SMP_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem_reg[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/abbr_ctrl.sv
// ----------------------------------------------------------------------------
// abbr_ctrl
// Block status, fill positions and ring pointers; issues sample memory
// requests and registers the result fields of each request.
// ----------------------------------------------------------------------------
module abbr_ctrl
    import abbr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [1:0]              operation,
    input  logic signed [SMP_W-1:0] sample,
    input  logic [7:0]              read_index,
    output mem_req_t                mem_req,
    output result_t                 res
);

    logic [1:0]       status_reg  [BLOCK_COUNT];
    logic [1:0]       status_next [BLOCK_COUNT];
    logic [POS_W-1:0] fill_reg    [BLOCK_COUNT];
    logic [POS_W-1:0] fill_next   [BLOCK_COUNT];
    logic [BLK_W-1:0] wr_blk_reg, wr_blk_next;
    logic [BLK_W-1:0] rd_blk_reg, rd_blk_next;

    logic             strobe_reg;
    logic [1:0]       state_reg;
    logic             dropped_reg;
    logic [1:0]       blk_reg;
    logic             fetch_ok_reg;

    logic             dropped;
    logic             do_store;
    logic [BLK_W-1:0] tgt;
    logic [BLK_W-1:0] nb;
    logic             fetch_ok;

    always_comb
    begin
        status_next = status_reg;
        fill_next   = fill_reg;
        wr_blk_next = wr_blk_reg;
        rd_blk_next = rd_blk_reg;
        dropped     = 1'b0;
        do_store    = 1'b0;
        tgt         = wr_blk_reg;
        nb          = next_blk(wr_blk_reg);
        fetch_ok    = 1'b0;
        mem_req     = '0;
        mem_req.wdata = sample;

        if (accept)
        begin
            case (operation)
                OP_PUSH:
                begin
                    case (status_reg[wr_blk_reg])
                        ST_EMPTY:
                        begin
                            status_next[wr_blk_reg] = ST_WRITTEN;
                            do_store = 1'b1;
                        end
                        ST_WRITTEN:
                        begin
                            if (32'(fill_reg[wr_blk_reg]) >= BLOCK_SAMPLES)
                            begin
                                // Push that finds this block complete: close the block and move on.
                                fill_next[wr_blk_reg]   = '0;
                                status_next[wr_blk_reg] = ST_FULL;
                                wr_blk_next             = nb;
                                tgt                     = nb;
                                if (status_reg[nb] == ST_EMPTY)
                                begin
                                    do_store = 1'b1;
                                end
                                else
                                begin
                                    dropped = 1'b1;
                                end
                            end
                            else
                            begin
                                do_store = 1'b1;
                            end
                        end
                        default:
                        begin
                            dropped = 1'b1;
                        end
                    endcase
                end
                OP_START:
                begin
                    status_next[rd_blk_reg] = ST_READ;
                end
                OP_FETCH:
                begin
                    fetch_ok      = (32'(read_index) < BLOCK_SAMPLES);
                    mem_req.re    = fetch_ok;
                    mem_req.raddr = sample_addr(rd_blk_reg, POS_W'(read_index));
                end
                default:
                begin
                    status_next[rd_blk_reg] = ST_EMPTY;
                    rd_blk_next             = next_blk(rd_blk_reg);
                end
            endcase
        end

        if (do_store)
        begin
            if (32'(fill_reg[tgt]) >= BLOCK_SAMPLES)
            begin
                dropped = 1'b1;
            end
            else
            begin
                mem_req.we     = 1'b1;
                mem_req.waddr  = sample_addr(tgt, fill_reg[tgt]);
                fill_next[tgt] = fill_reg[tgt] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BLOCK_COUNT; i++)
            begin
                status_reg[i] <= ST_EMPTY;
                fill_reg[i]   <= '0;
            end
            wr_blk_reg <= '0;
            rd_blk_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            status_reg <= status_next;
            fill_reg   <= fill_next;
            wr_blk_reg <= wr_blk_next;
            rd_blk_reg <= rd_blk_next;
            strobe_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            state_reg    <= status_next[rd_blk_next];
            dropped_reg  <= dropped;
            blk_reg      <= 2'(rd_blk_next);
            fetch_ok_reg <= fetch_ok;
        end
    end

    always_comb
    begin
        res.strobe   = strobe_reg;
        res.state    = state_reg;
        res.dropped  = dropped_reg;
        res.blk      = blk_reg;
        res.fetch_ok = fetch_ok_reg;
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg[wr_blk_reg]) <= BLOCK_SAMPLES)
        else $error("fill position beyond block size");

    a_write_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (accept && operation == OP_PUSH))
        else $error("sample write without a push request");

    a_drop_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation != OP_PUSH) |=> !res.dropped)
        else $error("drop flag on a request that is not a push");

    a_write_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && dropped))
        else $error("push both stored and dropped");
`endif

endmodule

// File: hdl/audio_block_buffer_ring.sv
// ----------------------------------------------------------------------------
// audio_block_buffer_ring
// Ring of sample blocks handed from a writer to a reader one block at a time.
// ----------------------------------------------------------------------------
// Each result strobes on done in the cycle after its request is taken.
// Throughput: one request per cycle; busy stays low, and the sample memory
// takes one write and one registered read in the same cycle.
// Reset: all blocks empty, fill positions and ring pointers zero; sample
// memory contents are undefined until written. The receiver cannot stall.
module audio_block_buffer_ring
    import abbr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              operation,
    input  logic signed [SMP_W-1:0] sample,
    input  logic [7:0]              read_index,
    output logic                    done,
    output logic [1:0]              reading_state,
    output logic signed [SMP_W-1:0] read_data,
    output logic                    sample_dropped,
    output logic [1:0]              reading_block
);

    mem_req_t                mem_req;
    result_t                 res;
    logic signed [SMP_W-1:0] mem_rdata;
    logic                    accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    abbr_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .sample     (sample),
        .read_index (read_index),
        .mem_req    (mem_req),
        .res        (res)
    );

    abbr_sample_mem u_mem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign done           = res.strobe;
    assign reading_state  = res.state;
    assign sample_dropped = res.dropped;
    assign reading_block  = res.blk;
    assign read_data      = res.fetch_ok ? mem_rdata : '0;

endmodule

// File: test/audio_block_buffer_ring_tb.sv
// ----------------------------------------------------------------------------
// audio_block_buffer_ring_tb
// Self-checking bench for the audio block buffer ring. A shadow copy of the
// ring tracks block status, fill positions, both ring pointers and the sample
// memory. It predicts every result of the request interface and
// checks it field by field. Stimulus is a short directed run, then writer
// bursts, reader sessions and noise under three sender idling profiles.
// ----------------------------------------------------------------------------
module audio_block_buffer_ring_tb
    import abbr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int FETCH_SPAN  = (BLOCK_SAMPLES < 256) ? BLOCK_SAMPLES : 256;

    typedef struct {
        logic [1:0]              state;
        logic signed [SMP_W-1:0] data;
        logic                    dropped;
        logic [1:0]              blk;
    } step_outcome_t;

    class ring_shadow;
        logic signed [SMP_W-1:0] samples [BLOCK_COUNT*BLOCK_SAMPLES];
        bit                      written [BLOCK_COUNT*BLOCK_SAMPLES];
        logic [1:0]              status [BLOCK_COUNT];
        int                      fill [BLOCK_COUNT];
        int                      wr_blk;
        int                      rd_blk;
        step_outcome_t           pending_outcomes[$];
        int                      mismatches;

        function new();
            for (int b = 0; b < BLOCK_COUNT; b++)
            begin
                status[b] = ST_EMPTY;
                fill[b]   = 0;
            end
            foreach (written[i])
            begin
                written[i] = 1'b0;
                samples[i] = '0;
            end
            wr_blk     = 0;
            rd_blk     = 0;
            mismatches = 0;
        endfunction

        // Returns 1 when the block has no room left at its fill position.
        function bit store_at(input int b, input logic signed [SMP_W-1:0] s);
            int p;
            p = fill[b];
            if (p >= BLOCK_SAMPLES)
            begin
                return 1'b1;
            end
            samples[b*BLOCK_SAMPLES + p] = s;
            written[b*BLOCK_SAMPLES + p] = 1'b1;
            fill[b] = p + 1;
            return 1'b0;
        endfunction

        function bit push_sample(input logic signed [SMP_W-1:0] s);
            int b;
            bit lost;
            b    = wr_blk;
            lost = 1'b0;
            case (status[b])
                ST_EMPTY:
                begin
                    status[b] = ST_WRITTEN;
                    lost = store_at(b, s);
                end
                ST_WRITTEN:
                begin
                    // A complete block is only closed by the push that follows it.
                    if (fill[b] >= BLOCK_SAMPLES)
                    begin
                        fill[b]   = 0;
                        status[b] = ST_FULL;
                        b = (b + 1) % BLOCK_COUNT;
                        wr_blk = b;
                        if (status[b] == ST_EMPTY)
                        begin
                            lost = store_at(b, s);
                        end
                        else
                        begin
                            lost = 1'b1;
                        end
                    end
                    else
                    begin
                        lost = store_at(b, s);
                    end
                end
                default:
                begin
                    lost = 1'b1;
                end
            endcase
            return lost;
        endfunction

        function void take_request(input logic [1:0] op, input logic signed [SMP_W-1:0] s,
                                   input logic [7:0] idx);
            step_outcome_t o;
            int rb;
            rb        = rd_blk;
            o.data    = '0;
            o.dropped = 1'b0;
            case (op)
                OP_PUSH:
                begin
                    o.dropped = push_sample(s);
                end
                OP_START:
                begin
                    status[rb] = ST_READ;
                end
                OP_FETCH:
                begin
                    if (int'(idx) < BLOCK_SAMPLES)
                    begin
                        o.data = samples[rb*BLOCK_SAMPLES + int'(idx)];
                    end
                end
                default:
                begin
                    status[rb] = ST_EMPTY;
                    rd_blk = (rb + 1) % BLOCK_COUNT;
                end
            endcase
            o.state = status[rd_blk];
            o.blk   = 2'(rd_blk);
            pending_outcomes.push_back(o);
        endfunction

        function void match_outcome(input logic [1:0] st, input logic signed [SMP_W-1:0] d,
                                    input logic drp, input logic [1:0] blk);
            step_outcome_t o;
            if (pending_outcomes.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("mismatch at %0t: result with no request waiting", $realtime);
                end
                mismatches++;
                return;
            end
            o = pending_outcomes.pop_front();
            if (o.state !== st || o.data !== d || o.dropped !== drp || o.blk !== blk)
            begin
                if (mismatches < 10)
                begin
                    $display("mismatch at %0t: state %0d/%0d data %0d/%0d dropped %0d/%0d blk %0d/%0d",
                             $realtime, o.state, st, o.data, d, o.dropped, drp, o.blk, blk);
                end
                mismatches++;
            end
        endfunction

        // Picks a sample position of the reading block that has been written,
        // or -1 when there is none.
        function int fetch_index();
            int base;
            int pos;
            int k;
            base = rd_blk * BLOCK_SAMPLES;
            pos  = $urandom_range(0, FETCH_SPAN - 1);
            for (k = 0; k < FETCH_SPAN; k++)
            begin
                if (written[base + (pos + k) % FETCH_SPAN])
                begin
                    return (pos + k) % FETCH_SPAN;
                end
            end
            return -1;
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              operation = OP_PUSH;
    logic signed [SMP_W-1:0] sample = '0;
    logic [7:0]              read_index = '0;
    logic                    done;
    logic [1:0]              reading_state;
    logic signed [SMP_W-1:0] read_data;
    logic                    sample_dropped;
    logic [1:0]              reading_block;

    ring_shadow ring = new();
    int         sender_idle_pct = 0;
    int         cycle_count = 0;

    audio_block_buffer_ring dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .sample         (sample),
        .read_index     (read_index),
        .done           (done),
        .reading_state  (reading_state),
        .read_data      (read_data),
        .sample_dropped (sample_dropped),
        .reading_block  (reading_block)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            ring.match_outcome(reading_state, read_data, sample_dropped, reading_block);
        end
    end

    task automatic send_request(input logic [1:0] op, input logic signed [SMP_W-1:0] smp,
                                input logic [7:0] idx);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        operation  <= op;
        sample     <= smp;
        read_index <= idx;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        ring.take_request(op, smp, idx);
    endtask

    // Holds the sender off until every request has been answered.
    task automatic drain_results();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (ring.outstanding() != 0);
    endtask

    task automatic run_phase(input int budget);
        int sent;
        int kind;
        int n;
        int pick;
        logic [1:0] op;
        sent = 0;
        while (sent < budget)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                // Writer burst; the long ones close blocks and run into the reader.
                if ($urandom_range(0, 9) < 3)
                begin
                    n = $urandom_range(1, 300);
                end
                else
                begin
                    n = $urandom_range(1, 20);
                end
                if (n > budget - sent)
                begin
                    n = budget - sent;
                end
                repeat (n)
                begin
                    send_request(OP_PUSH, SMP_W'($urandom), 8'($urandom));
                    sent++;
                end
            end
            else if (kind < 80)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    drain_results();
                end
                send_request(OP_START, SMP_W'($urandom), 8'($urandom));
                sent++;
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    pick = ring.fetch_index();
                    if (pick >= 0)
                    begin
                        send_request(OP_FETCH, SMP_W'($urandom), 8'(pick));
                        sent++;
                    end
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    send_request(OP_RELEASE, SMP_W'($urandom), 8'($urandom));
                    sent++;
                end
            end
            else if (kind < 90)
            begin
                op = ($urandom_range(0, 1) == 0) ? OP_START : OP_RELEASE;
                send_request(op, SMP_W'($urandom), 8'($urandom));
                sent++;
            end
            else
            begin
                op = 2'($urandom);
                if (op == OP_FETCH)
                begin
                    pick = ring.fetch_index();
                    if (pick >= 0)
                    begin
                        send_request(OP_FETCH, SMP_W'($urandom), 8'(pick));
                        sent++;
                    end
                end
                else
                begin
                    send_request(op, SMP_W'($urandom), 8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (11)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        // Directed: extreme samples, fetch from a written block, push into a
        // block in read, reuse of a released partial block, reader wrap.
        send_request(OP_PUSH, 16'sh7FFF, 8'hFF);
        send_request(OP_PUSH, 16'sh8000, 8'h00);
        send_request(OP_PUSH, 16'sh0000, 8'hAA);
        send_request(OP_PUSH, 16'shFFFF, 8'h55);
        send_request(OP_FETCH, 16'sh0000, 8'd0);
        send_request(OP_FETCH, 16'shFFFF, 8'd1);
        send_request(OP_FETCH, 16'sh0000, 8'd2);
        send_request(OP_FETCH, 16'sh0000, 8'd3);
        send_request(OP_START, 16'sh1234, 8'h00);
        send_request(OP_PUSH, 16'sh5A5A, 8'h00);
        send_request(OP_FETCH, 16'sh0000, 8'd3);
        send_request(OP_RELEASE, 16'sh0000, 8'hFF);
        send_request(OP_PUSH, 16'shA5A5, 8'h00);
        send_request(OP_RELEASE, 16'sh0000, 8'h00);
        send_request(OP_START, 16'sh0000, 8'h00);
        send_request(OP_RELEASE, 16'sh0000, 8'h00);
        send_request(OP_RELEASE, 16'sh0000, 8'h00);
        send_request(OP_FETCH, 16'sh0000, 8'd4);
        send_request(OP_FETCH, 16'sh0000, 8'd0);
        drain_results();

        sender_idle_pct = 35;
        run_phase(400);
        drain_results();
        sender_idle_pct = 63;
        run_phase(400);
        drain_results();
        sender_idle_pct = 0;
        run_phase(400);
        drain_results();

        repeat (5)
        begin
            @(posedge clk);
        end
        if (ring.mismatches == 0 && ring.outstanding() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
